### rtl/core/ahfc_pkg.sv
// Package for the application header format checker: byte classes, header text and helpers.
package ahfc_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 6;   // word index within a header
  localparam int unsigned BPOS_W = 7;   // byte index within a header
  localparam int unsigned DESC_W = 16;
  localparam int unsigned NIB_W  = 4;

  localparam logic [POS_W-1:0] LAST_WORD     = 6'd63;
  localparam logic [POS_W-1:0] HEX_WORD_LO   = 6'd62;

  localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;
  localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHR_DASH  = 8'h2D;
  localparam logic [BYTE_W-1:0] CHR_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CHR_A     = 8'h41;
  localparam logic [BYTE_W-1:0] CHR_S     = 8'h53;

  localparam logic [15:0] MAGIC_TEXT = "RP";
  localparam logic [87:0] AUTH_TEXT  = "\n\nAppAuth: ";
  localparam logic [79:0] NAME_TEXT  = "\nAppName: ";
  localparam logic [79:0] VER_TEXT   = "\nVersion: ";
  localparam logic [79:0] ENG_TEXT   = "\nEngSpec: ";
  localparam logic [79:0] DESC_TEXT  = "\nDescOff: ";

  typedef enum logic [2:0] {
    CLS_LIT,
    CLS_TYPE,
    CLS_UID_FIRST,
    CLS_UID,
    CLS_PRINT,
    CLS_DIGIT,
    CLS_HEX
  } byte_class_t;

  // Result of one byte check.
  typedef struct packed {
    logic             ok;
    logic [NIB_W-1:0] nibble;
  } byte_check_t;

  function automatic logic in_span(logic [BPOS_W-1:0] p, logic [BPOS_W-1:0] lo,
                                   logic [BPOS_W-1:0] hi);
    return (p >= lo) && (p <= hi);
  endfunction

  function automatic byte_class_t class_of(logic [BPOS_W-1:0] p);
    byte_class_t c;
    c = CLS_HEX;
    if (p == 7'd2)                                      c = CLS_TYPE;
    else if (p == 7'd14)                                c = CLS_UID_FIRST;
    else if (in_span(p, 7'd15, 7'd29))                  c = CLS_UID;
    else if (in_span(p, 7'd40, 7'd73))                  c = CLS_PRINT;
    else if (p == 7'd86 || p == 7'd90 || p == 7'd106 || p == 7'd110) c = CLS_LIT;
    else if (in_span(p, 7'd84, 7'd93) || in_span(p, 7'd104, 7'd113)) c = CLS_DIGIT;
    else if (p <= 7'd123)                               c = CLS_LIT;
    return c;
  endfunction

  // Expected byte at a literal position; first character sits in the text's top byte.
  function automatic logic [BYTE_W-1:0] lit_byte(logic [BPOS_W-1:0] p);
    logic [BYTE_W-1:0] b;
    logic [BPOS_W-1:0] k;
    b = CHR_DOT;
    k = '0;
    if (p <= 7'd1) begin
      k = p;
      b = MAGIC_TEXT[(4'd1 - k[3:0]) * 8 +: 8];
    end else if (in_span(p, 7'd3, 7'd13)) begin
      k = p - 7'd3;
      b = AUTH_TEXT[(4'd10 - k[3:0]) * 8 +: 8];
    end else if (in_span(p, 7'd30, 7'd39)) begin
      k = p - 7'd30;
      b = NAME_TEXT[(4'd9 - k[3:0]) * 8 +: 8];
    end else if (in_span(p, 7'd74, 7'd83)) begin
      k = p - 7'd74;
      b = VER_TEXT[(4'd9 - k[3:0]) * 8 +: 8];
    end else if (in_span(p, 7'd94, 7'd103)) begin
      k = p - 7'd94;
      b = ENG_TEXT[(4'd9 - k[3:0]) * 8 +: 8];
    end else if (in_span(p, 7'd114, 7'd123)) begin
      k = p - 7'd114;
      b = DESC_TEXT[(4'd9 - k[3:0]) * 8 +: 8];
    end
    return b;
  endfunction

  function automatic logic is_digit(logic [BYTE_W-1:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_hex(logic [BYTE_W-1:0] b);
    return is_digit(b) || ((b >= 8'h41) && (b <= 8'h46));
  endfunction

  // Value of an uppercase hex digit; 'A' has low nibble 1.
  function automatic logic [NIB_W-1:0] hex_value(logic [BYTE_W-1:0] b);
    return is_digit(b) ? b[NIB_W-1:0] : (b[NIB_W-1:0] + 4'd9);
  endfunction

endpackage

### rtl/core/ahfc_byte_check.sv
// Checks one header byte against the rule for its byte position.
module ahfc_byte_check (
  input  logic [ahfc_pkg::BPOS_W-1:0] pos,
  input  logic [ahfc_pkg::BYTE_W-1:0] data,
  output ahfc_pkg::byte_check_t       result
);

  ahfc_pkg::byte_class_t cls;
  logic                  uid_char;

  assign cls = ahfc_pkg::class_of(pos);

  assign uid_char = ((data >= 8'h61) && (data <= 8'h7A)) ||
                    ((data >= 8'h41) && (data <= 8'h5A)) ||
                    ahfc_pkg::is_digit(data) || (data == ahfc_pkg::CHR_DASH);

  always_comb begin
    result.nibble = ahfc_pkg::hex_value(data);
    unique case (cls)
      ahfc_pkg::CLS_LIT:       result.ok = (data == ahfc_pkg::lit_byte(pos));
      ahfc_pkg::CLS_TYPE:      result.ok = (data == ahfc_pkg::CHR_A) ||
                                           (data == ahfc_pkg::CHR_S);
      ahfc_pkg::CLS_UID_FIRST: result.ok = uid_char;
      ahfc_pkg::CLS_UID:       result.ok = uid_char || (data == ahfc_pkg::CHR_SPACE);
      ahfc_pkg::CLS_PRINT:     result.ok = (data >= ahfc_pkg::PRINT_LO) &&
                                           (data <= ahfc_pkg::PRINT_HI);
      ahfc_pkg::CLS_DIGIT:     result.ok = ahfc_pkg::is_digit(data);
      ahfc_pkg::CLS_HEX:       result.ok = ahfc_pkg::is_hex(data);
      default:                 result.ok = 1'b0;
    endcase
  end

endmodule

### rtl/core/app_header_format_checker.sv
// Top level of the application header format checker.
//
//   channel | direction | tdata fields (low bit up)                   | tlast/tuser
//   s_*     | in        | header_word[15:0]                           | none
//   m_*     | out       | status[0], fault_word[6:1],                 | none
//           |           | descriptor_offset[22:7], zero pad [23]      |
//
// One word per cycle while no result stalls: a word is held in the input register, then
// both of its bytes are checked at once and the header state is updated. After word 63
// is checked, its result and m_tvalid are registered.
// Synchronous active-high reset clears the word count, the fault state, the hex value
// and both valid flags. Only the last word of a header waits on a stalled result
// register; the other 63 words keep flowing while a result is pending.
module app_header_format_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // header_word[15:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status[0], fault_word[6:1], descriptor_offset[22:7]
);

  // Input register.
  logic                          in_valid;
  logic [ahfc_pkg::WORD_W-1:0]   in_word;

  // Header state.
  logic [ahfc_pkg::POS_W-1:0]    word_position;
  logic                          fault_seen;
  logic [ahfc_pkg::POS_W-1:0]    first_fault_word;
  logic [ahfc_pkg::DESC_W-1:0]   hex_accumulator;

  // Result register.
  logic                          status;
  logic [ahfc_pkg::POS_W-1:0]    fault_word;
  logic [ahfc_pkg::DESC_W-1:0]   descriptor_offset;

  ahfc_pkg::byte_check_t         chk_hi;
  ahfc_pkg::byte_check_t         chk_lo;
  logic                          last_word;
  logic                          advance;
  logic                          take;
  logic                          fault_next;
  logic [ahfc_pkg::POS_W-1:0]    first_fault_word_next;
  logic [ahfc_pkg::DESC_W-1:0]   acc_mid;
  logic [ahfc_pkg::DESC_W-1:0]   hex_accumulator_next;
  logic                          hex_word;

  // Even byte in the high half, odd byte in the low half.
  ahfc_byte_check u_check_hi (
    .pos    ({word_position, 1'b0}),
    .data   (in_word[15:8]),
    .result (chk_hi)
  );

  ahfc_byte_check u_check_lo (
    .pos    ({word_position, 1'b1}),
    .data   (in_word[7:0]),
    .result (chk_lo)
  );

  assign last_word = (word_position == ahfc_pkg::LAST_WORD);
  // Hold the last word only while an earlier result still waits to be taken.
  assign advance   = in_valid && !(last_word && m_tvalid && !m_tready);
  assign s_tready  = !in_valid || advance;
  assign take      = s_tvalid && s_tready;
  assign hex_word  = (word_position >= ahfc_pkg::HEX_WORD_LO);

  always_comb begin
    fault_next            = fault_seen || !chk_hi.ok || !chk_lo.ok;
    first_fault_word_next = fault_seen ? first_fault_word : word_position;
    // Shift in only good hex digits; a bad one marks the header faulty anyway.
    acc_mid               = (hex_word && chk_hi.ok) ?
                            {hex_accumulator[11:0], chk_hi.nibble} : hex_accumulator;
    hex_accumulator_next  = (hex_word && chk_lo.ok) ?
                            {acc_mid[11:0], chk_lo.nibble} : acc_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_word <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position    <= '0;
      fault_seen       <= 1'b0;
      first_fault_word <= '0;
      hex_accumulator  <= '0;
    end else if (advance) begin
      if (last_word) begin
        // Start over for the next header.
        word_position    <= '0;
        fault_seen       <= 1'b0;
        first_fault_word <= '0;
        hex_accumulator  <= '0;
      end else begin
        word_position    <= word_position + 6'd1;
        fault_seen       <= fault_next;
        first_fault_word <= first_fault_word_next;
        hex_accumulator  <= hex_accumulator_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && last_word) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_word) begin
      status            <= fault_next;
      fault_word        <= fault_next ? first_fault_word_next : '0;
      descriptor_offset <= fault_next ? '0 : hex_accumulator_next;
    end
  end

  assign m_tdata = {1'b0, descriptor_offset, fault_word, status};

  // A finished header leaves the counter at the start of the next one.
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    (advance && last_word) |=> (word_position == '0) && !fault_seen)
    else $error("word position not cleared after last word");

  // A valid header reports word index zero.
  a_ok_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !status) |-> (fault_word == '0))
    else $error("valid header with nonzero fault word");

  // A faulty header reports no descriptor offset.
  a_fault_desc: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status) |-> (descriptor_offset == '0))
    else $error("faulty header with nonzero descriptor offset");

  // Input stalls only behind a pending last word and an unaccepted result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && last_word && m_tvalid && !m_tready))
    else $error("input stalled without a pending result");

endmodule
